>>> hw/rtl/small_language_tokenizer_unit_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef SMALL_LANGUAGE_TOKENIZER_UNIT_MACROS_SVH
`define SMALL_LANGUAGE_TOKENIZER_UNIT_MACROS_SVH

`ifndef SYNTH
// Checks that an expression holds at every clock edge outside reset.
`define SLT_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("slt assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define SLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slt assertion failed");
// Checks that the consequent holds in the same cycle as the antecedent.
`define SLT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slt assertion failed");
`else
`define SLT_ASSERT_ALWAYS(label, clk, rst, expr)
`define SLT_ASSERT_NEXT(label, clk, rst, ante, cons)
`define SLT_ASSERT_IMPL(label, clk, rst, ante, cons)
`endif

`endif

>>> hw/rtl/slt_pkg.sv
// Types and constants shared by the tokenizer RTL.
`timescale 1ns / 1ps
package slt_pkg;

   localparam int MAX_TEXT   = 63;
   localparam int VALUE_BITS = 32;
   localparam int TEXT_W     = $clog2(MAX_TEXT + 1);
   localparam int CHAR_W     = 8;
   localparam int KIND_W     = 5;
   localparam int KWBUF_W    = 32;

   typedef enum logic [KIND_W-1:0] {
      TK_END    = 5'd0,
      TK_LET    = 5'd1,
      TK_IF     = 5'd2,
      TK_ELSE   = 5'd3,
      TK_EXIT   = 5'd4,
      TK_IDENT  = 5'd5,
      TK_INT    = 5'd6,
      TK_ASSIGN = 5'd7,
      TK_EQ     = 5'd8,
      TK_NEQ    = 5'd9,
      TK_LT     = 5'd10,
      TK_LTE    = 5'd11,
      TK_GT     = 5'd12,
      TK_GTE    = 5'd13,
      TK_SEMI   = 5'd14,
      TK_LPAREN = 5'd15,
      TK_RPAREN = 5'd16,
      TK_LBRACE = 5'd17,
      TK_RBRACE = 5'd18,
      TK_ERROR  = 5'd19
   } token_kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_IDENT  = 2'd1,
      MODE_NUMBER = 2'd2,
      MODE_OP     = 2'd3
   } scan_mode_type;

   typedef enum logic [1:0] {
      OP_ASSIGN = 2'd0,
      OP_BANG   = 2'd1,
      OP_LT     = 2'd2,
      OP_GT     = 2'd3
   } pending_op_type;

   typedef struct packed {
      token_kind_type               kind;
      logic [TEXT_W-1:0]            length;
      logic [VALUE_BITS-1:0]        value;
   } token_type;

   typedef struct packed {
      token_type tok;
      logic      last;
   } rsp_entry_type;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE       = 8'h39;
   localparam logic [CHAR_W-1:0] CH_LOW_A      = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOW_Z      = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_UP_A       = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_Z       = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_EQUALS     = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_BANG       = 8'h21;
   localparam logic [CHAR_W-1:0] CH_LESS       = 8'h3C;
   localparam logic [CHAR_W-1:0] CH_GREATER    = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_SEMI       = 8'h3B;
   localparam logic [CHAR_W-1:0] CH_LPAREN     = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN     = 8'h29;
   localparam logic [CHAR_W-1:0] CH_LBRACE     = 8'h7B;
   localparam logic [CHAR_W-1:0] CH_RBRACE     = 8'h7D;

   // Keyword spellings, last character in the low byte
   localparam logic [KWBUF_W-1:0] KW_LET  = 32'h006C6574;
   localparam logic [KWBUF_W-1:0] KW_IF   = 32'h00006966;
   localparam logic [KWBUF_W-1:0] KW_ELSE = 32'h656C7365;
   localparam logic [KWBUF_W-1:0] KW_EXIT = 32'h65786974;

endpackage

>>> hw/rtl/slt_req_if.sv
// Request channel carrying one source byte per transfer.
`timescale 1ns / 1ps
interface slt_req_if;
   logic                          valid;
   logic                          ready;
   logic [slt_pkg::CHAR_W-1:0]    char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

// Response channel carrying one token per transfer.
interface slt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [slt_pkg::KIND_W-1:0]       token_kind;
   logic [slt_pkg::TEXT_W-1:0]       token_length;
   logic [slt_pkg::VALUE_BITS-1:0]   int_value;
   logic                             last_of_run;

   modport source (output valid, output token_kind, output token_length,
                   output int_value, output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input token_length,
                   input int_value, input last_of_run, output ready);
endinterface

>>> hw/rtl/small_language_tokenizer_unit.sv
// Streaming tokenizer: source bytes in, tokens out.
`timescale 1ns / 1ps
`include "small_language_tokenizer_unit_macros.svh"

// Each request carries one source byte, byte 0 ending the input. A byte is
// registered and scanned once the queue has room for two tokens; the scan
// yields zero, one or two tokens, which go into a four-entry response queue.
// A new byte is taken in every cycle as long as the queue has room for two
// tokens, so the block sustains one byte per cycle, limited only by the
// response side taking one token per cycle when bytes produce more than one
// token on average; tokens reach the output through the byte register and queue.
module small_language_tokenizer_unit (
   input  logic        clock,
   input  logic        reset,
   slt_req_if.sink     req_chan,
   slt_rsp_if.source   rsp_chan
);

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);
   localparam logic [QCNT_W-1:0] QROOM = QCNT_W'(QDEPTH - 2);
   localparam logic [slt_pkg::TEXT_W-1:0] TEXT_MAX = slt_pkg::TEXT_W'(slt_pkg::MAX_TEXT);

   // Input register
   logic [slt_pkg::CHAR_W-1:0] byte_ff;
   logic                       byte_valid_ff;

   // Scanner state
   slt_pkg::scan_mode_type        mode_ff, mode_in;
   slt_pkg::pending_op_type       pend_ff, pend_in;
   logic [slt_pkg::KWBUF_W-1:0]   kwbuf_ff, kwbuf_in;
   logic [slt_pkg::TEXT_W-1:0]    count_ff, count_in;
   logic [slt_pkg::VALUE_BITS-1:0] acc_ff, acc_in;

   // Response queue
   slt_pkg::rsp_entry_type q_ff [QDEPTH];
   logic [QPTR_W-1:0]      head_ff, tail_ff;
   logic [QCNT_W-1:0]      qcount_ff, qcount_in;

   logic             proc_fire, req_fire, pop;
   slt_pkg::token_type tok0, tok1, fl_tok, st_tok;
   logic [1:0]       n_tok;
   logic             fl_valid, fl_emit, st_valid;
   logic             is_space, is_alpha, is_digit, is_word;
   logic [slt_pkg::TEXT_W-1:0] count_sat;

   assign proc_fire        = byte_valid_ff && (qcount_ff <= QROOM);
   assign req_chan.ready   = !byte_valid_ff || proc_fire;
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = (qcount_ff != '0);
   assign pop              = rsp_chan.valid && rsp_chan.ready;

   assign rsp_chan.token_kind   = q_ff[head_ff].tok.kind;
   assign rsp_chan.token_length = q_ff[head_ff].tok.length;
   assign rsp_chan.int_value    = q_ff[head_ff].tok.value;
   assign rsp_chan.last_of_run  = q_ff[head_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else if (req_fire) begin
         byte_valid_ff <= 1'b1;
      end else if (proc_fire) begin
         byte_valid_ff <= 1'b0;
      end
      if (req_fire) begin
         byte_ff <= req_chan.char_code;
      end
   end

   always_comb begin
      is_space = (byte_ff == slt_pkg::CH_SPACE) ||
                 ((byte_ff >= slt_pkg::CH_TAB) && (byte_ff <= slt_pkg::CH_CR));
      is_alpha = ((byte_ff >= slt_pkg::CH_LOW_A) && (byte_ff <= slt_pkg::CH_LOW_Z)) ||
                 ((byte_ff >= slt_pkg::CH_UP_A) && (byte_ff <= slt_pkg::CH_UP_Z));
      is_digit = (byte_ff >= slt_pkg::CH_ZERO) && (byte_ff <= slt_pkg::CH_NINE);
      is_word  = is_alpha || is_digit || (byte_ff == slt_pkg::CH_UNDERSCORE);
      count_sat = (count_ff < TEXT_MAX) ? count_ff + 1'b1 : count_ff;
   end

   // Token that the current state gives when it is ended by this byte.
   always_comb begin
      fl_valid = (mode_ff != slt_pkg::MODE_IDLE);
      fl_tok   = '{kind: slt_pkg::TK_IDENT, length: count_ff, value: '0};
      unique case (mode_ff)
         slt_pkg::MODE_IDENT: begin
            if (count_ff == slt_pkg::TEXT_W'(3) && kwbuf_ff == slt_pkg::KW_LET) begin
               fl_tok.kind = slt_pkg::TK_LET;
            end else if (count_ff == slt_pkg::TEXT_W'(2) && kwbuf_ff == slt_pkg::KW_IF) begin
               fl_tok.kind = slt_pkg::TK_IF;
            end else if (count_ff == slt_pkg::TEXT_W'(4) && kwbuf_ff == slt_pkg::KW_ELSE) begin
               fl_tok.kind = slt_pkg::TK_ELSE;
            end else if (count_ff == slt_pkg::TEXT_W'(4) && kwbuf_ff == slt_pkg::KW_EXIT) begin
               fl_tok.kind = slt_pkg::TK_EXIT;
            end
         end
         slt_pkg::MODE_NUMBER: begin
            fl_tok.kind  = slt_pkg::TK_INT;
            fl_tok.value = acc_ff;
         end
         slt_pkg::MODE_OP: begin
            fl_tok.length = slt_pkg::TEXT_W'(1);
            unique case (pend_ff)
               slt_pkg::OP_ASSIGN: fl_tok.kind = slt_pkg::TK_ASSIGN;
               slt_pkg::OP_BANG:   fl_tok.kind = slt_pkg::TK_ERROR;
               slt_pkg::OP_LT:     fl_tok.kind = slt_pkg::TK_LT;
               slt_pkg::OP_GT:     fl_tok.kind = slt_pkg::TK_GT;
               default:            fl_tok.kind = slt_pkg::TK_ERROR;
            endcase
         end
         default: begin
            fl_tok.length = '0;
         end
      endcase
   end

   // Next state and tokens for one scanned byte.
   always_comb begin
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      kwbuf_in = kwbuf_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      fl_emit  = fl_valid;
      st_valid = 1'b0;
      st_tok   = '{kind: slt_pkg::TK_ERROR, length: slt_pkg::TEXT_W'(1), value: '0};
      tok0     = fl_tok;
      tok1     = fl_tok;
      n_tok    = 2'd0;

      priority if (byte_ff == slt_pkg::CH_NUL) begin
         mode_in  = slt_pkg::MODE_IDLE;
         pend_in  = slt_pkg::OP_ASSIGN;
         kwbuf_in = '0;
         count_in = '0;
         acc_in   = '0;
         st_valid = 1'b1;
         st_tok   = '{kind: slt_pkg::TK_END, length: '0, value: '0};
      end else if (mode_ff == slt_pkg::MODE_IDENT && is_word) begin
         fl_emit = 1'b0;
         if (count_ff < TEXT_MAX) begin
            kwbuf_in = {kwbuf_ff[slt_pkg::KWBUF_W-slt_pkg::CHAR_W-1:0], byte_ff};
         end
         count_in = count_sat;
      end else if (mode_ff == slt_pkg::MODE_NUMBER && is_digit) begin
         fl_emit  = 1'b0;
         acc_in   = (acc_ff << 3) + (acc_ff << 1) +
                    slt_pkg::VALUE_BITS'(byte_ff[3:0]);
         count_in = count_sat;
      end else if (mode_ff == slt_pkg::MODE_OP && byte_ff == slt_pkg::CH_EQUALS) begin
         // Two-character operator: replaces the pending one-character token.
         fl_emit  = 1'b0;
         st_valid = 1'b1;
         st_tok.length = slt_pkg::TEXT_W'(2);
         unique case (pend_ff)
            slt_pkg::OP_ASSIGN: st_tok.kind = slt_pkg::TK_EQ;
            slt_pkg::OP_BANG:   st_tok.kind = slt_pkg::TK_NEQ;
            slt_pkg::OP_LT:     st_tok.kind = slt_pkg::TK_LTE;
            slt_pkg::OP_GT:     st_tok.kind = slt_pkg::TK_GTE;
            default:            st_tok.kind = slt_pkg::TK_ERROR;
         endcase
         mode_in  = slt_pkg::MODE_IDLE;
         pend_in  = slt_pkg::OP_ASSIGN;
         kwbuf_in = '0;
         count_in = '0;
         acc_in   = '0;
      end else begin
         // Any pending token ends here; the byte starts a new one unless it is blank or a token itself.
         mode_in  = slt_pkg::MODE_IDLE;
         pend_in  = slt_pkg::OP_ASSIGN;
         kwbuf_in = '0;
         count_in = '0;
         acc_in   = '0;
         priority if (is_space) begin
            st_valid = 1'b0;
         end else if (is_alpha || byte_ff == slt_pkg::CH_UNDERSCORE) begin
            mode_in  = slt_pkg::MODE_IDENT;
            count_in = slt_pkg::TEXT_W'(1);
            kwbuf_in = slt_pkg::KWBUF_W'(byte_ff);
         end else if (is_digit) begin
            mode_in  = slt_pkg::MODE_NUMBER;
            count_in = slt_pkg::TEXT_W'(1);
            acc_in   = slt_pkg::VALUE_BITS'(byte_ff[3:0]);
         end else begin
            unique case (byte_ff)
               slt_pkg::CH_EQUALS: begin
                  mode_in = slt_pkg::MODE_OP;
                  pend_in = slt_pkg::OP_ASSIGN;
               end
               slt_pkg::CH_BANG: begin
                  mode_in = slt_pkg::MODE_OP;
                  pend_in = slt_pkg::OP_BANG;
               end
               slt_pkg::CH_LESS: begin
                  mode_in = slt_pkg::MODE_OP;
                  pend_in = slt_pkg::OP_LT;
               end
               slt_pkg::CH_GREATER: begin
                  mode_in = slt_pkg::MODE_OP;
                  pend_in = slt_pkg::OP_GT;
               end
               slt_pkg::CH_SEMI: begin
                  st_valid    = 1'b1;
                  st_tok.kind = slt_pkg::TK_SEMI;
               end
               slt_pkg::CH_LPAREN: begin
                  st_valid    = 1'b1;
                  st_tok.kind = slt_pkg::TK_LPAREN;
               end
               slt_pkg::CH_RPAREN: begin
                  st_valid    = 1'b1;
                  st_tok.kind = slt_pkg::TK_RPAREN;
               end
               slt_pkg::CH_LBRACE: begin
                  st_valid    = 1'b1;
                  st_tok.kind = slt_pkg::TK_LBRACE;
               end
               slt_pkg::CH_RBRACE: begin
                  st_valid    = 1'b1;
                  st_tok.kind = slt_pkg::TK_RBRACE;
               end
               default: begin
                  st_valid    = 1'b1;
                  st_tok.kind = slt_pkg::TK_ERROR;
               end
            endcase
         end
      end

      if (fl_emit) begin
         tok0 = fl_tok;
         tok1 = st_tok;
      end else begin
         tok0 = st_tok;
      end
      n_tok = {1'b0, fl_emit} + {1'b0, st_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= slt_pkg::MODE_IDLE;
         pend_ff  <= slt_pkg::OP_ASSIGN;
         kwbuf_ff <= '0;
         count_ff <= '0;
         acc_ff   <= '0;
      end else if (proc_fire) begin
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         kwbuf_ff <= kwbuf_in;
         count_ff <= count_in;
         acc_ff   <= acc_in;
      end
   end

   always_comb begin
      qcount_in = qcount_ff - QCNT_W'(pop);
      if (proc_fire) begin
         qcount_in = qcount_in + QCNT_W'(n_tok);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         qcount_ff <= '0;
      end else begin
         qcount_ff <= qcount_in;
         if (pop) begin
            head_ff <= head_ff + 1'b1;
         end
         if (proc_fire) begin
            tail_ff <= tail_ff + QPTR_W'(n_tok);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (proc_fire && n_tok != 2'd0) begin
         q_ff[tail_ff] <= '{tok: tok0, last: (n_tok == 2'd1)};
      end
      if (proc_fire && n_tok == 2'd2) begin
         q_ff[tail_ff + 1'b1] <= '{tok: tok1, last: 1'b1};
      end
   end

   `SLT_ASSERT_ALWAYS(a_queue_bound, clock, reset, qcount_ff <= QCNT_W'(QDEPTH))
   `SLT_ASSERT_NEXT(a_end_clears, clock, reset, proc_fire && byte_ff == slt_pkg::CH_NUL,
      mode_ff == slt_pkg::MODE_IDLE && count_ff == '0 && acc_ff == '0)
   `SLT_ASSERT_IMPL(a_count_mode, clock, reset,
      mode_ff == slt_pkg::MODE_IDLE || mode_ff == slt_pkg::MODE_OP, count_ff == '0)
   `SLT_ASSERT_IMPL(a_pair_whole, clock, reset,
      rsp_chan.valid && !rsp_chan.last_of_run, qcount_ff >= QCNT_W'(2))

endmodule

>>> tb/tb.sv
// Self-checking testbench for the streaming tokenizer: byte requests in, tokens out.
`timescale 1ns / 1ps
module tb;
   import slt_pkg::*;

   localparam int RANDOM_ITEMS   = 1350;
   localparam int CALM_TAIL      = 150;
   localparam int HOLD_AT        = 400;
   localparam int HOLD_CYCLES    = 48;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;

   typedef struct {
      logic [CHAR_W-1:0] code;
      bit                typed;
      token_kind_type    kind;
      logic [TEXT_W-1:0] len;
   } stim_row_type;

   logic clock;
   logic reset;

   slt_req_if req_if ();
   slt_rsp_if rsp_if ();

   small_language_tokenizer_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // The opening rows and the last carry their token; the rest rely on the predictor.
   stim_row_type directed_rows [25] = '{
      '{CH_NUL,     1'b1, TK_END,    6'd0},
      '{8'hFF,      1'b1, TK_ERROR,  6'd1},
      '{CH_LPAREN,  1'b1, TK_LPAREN, 6'd1},
      '{CH_RBRACE,  1'b1, TK_RBRACE, 6'd1},
      '{"1",        1'b0, TK_END,    6'd0},
      '{"2",        1'b0, TK_END,    6'd0},
      '{"a",        1'b0, TK_END,    6'd0},
      '{"b",        1'b0, TK_END,    6'd0},
      '{CH_BANG,    1'b0, TK_END,    6'd0},
      '{"x",        1'b0, TK_END,    6'd0},
      '{8'h7F,      1'b0, TK_END,    6'd0},
      '{CH_LESS,    1'b0, TK_END,    6'd0},
      '{CH_EQUALS,  1'b0, TK_END,    6'd0},
      '{CH_GREATER, 1'b0, TK_END,    6'd0},
      '{CH_GREATER, 1'b0, TK_END,    6'd0},
      '{CH_BANG,    1'b0, TK_END,    6'd0},
      '{CH_EQUALS,  1'b0, TK_END,    6'd0},
      '{CH_EQUALS,  1'b0, TK_END,    6'd0},
      '{CH_EQUALS,  1'b0, TK_END,    6'd0},
      '{CH_EQUALS,  1'b0, TK_END,    6'd0},
      '{CH_NUL,     1'b0, TK_END,    6'd0},
      '{"i",        1'b0, TK_END,    6'd0},
      '{"f",        1'b0, TK_END,    6'd0},
      '{CH_TAB,     1'b0, TK_END,    6'd0},
      '{8'h80,      1'b1, TK_ERROR,  6'd1}
   };

   string             keyword_text  [4] = '{"let", "if", "else", "exit"};
   string             operator_text [8] = '{"=", "==", "!=", "<", "<=", ">", ">=", "!"};
   logic [CHAR_W-1:0] symbol_code   [5] = '{CH_SEMI, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE};
   logic [CHAR_W-1:0] blank_code    [6] = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};

   stim_row_type  stimulus [$];
   rsp_entry_type byte_tokens [$];
   rsp_entry_type expected_tokens [$];

   // Predictor state for the token being scanned.
   scan_mode_type        lex_mode;
   pending_op_type       lex_op;
   logic [KWBUF_W-1:0]   lex_spelling;
   logic [TEXT_W-1:0]    lex_count;
   logic [VALUE_BITS-1:0] lex_number;

   int  random_bytes;
   int  bytes_accepted;
   int  mismatches;
   int  quiet_cycles;
   bit  calm_tail;
   bit  hold_active;
   bit  pressure_done;

   function automatic bit is_blank(input logic [CHAR_W-1:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic bit is_letter(input logic [CHAR_W-1:0] c);
      return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
   endfunction

   function automatic bit is_digit(input logic [CHAR_W-1:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic void emit_token(input token_kind_type kind, input logic [TEXT_W-1:0] len,
                                      input logic [VALUE_BITS-1:0] value);
      rsp_entry_type t;
      t.tok.kind   = kind;
      t.tok.length = len;
      t.tok.value  = value;
      t.last       = 1'b0;
      byte_tokens.push_back(t);
   endfunction

   function automatic void clear_lexeme();
      lex_mode     = MODE_IDLE;
      lex_op       = OP_ASSIGN;
      lex_spelling = '0;
      lex_count    = '0;
      lex_number   = '0;
   endfunction

   function automatic void flush_lexeme();
      token_kind_type kind;
      case (lex_mode)
         MODE_IDENT: begin
            kind = TK_IDENT;
            if (lex_count == 3 && lex_spelling == KW_LET) kind = TK_LET;
            else if (lex_count == 2 && lex_spelling == KW_IF) kind = TK_IF;
            else if (lex_count == 4 && lex_spelling == KW_ELSE) kind = TK_ELSE;
            else if (lex_count == 4 && lex_spelling == KW_EXIT) kind = TK_EXIT;
            emit_token(kind, lex_count, '0);
         end
         MODE_NUMBER: emit_token(TK_INT, lex_count, lex_number);
         MODE_OP: begin
            case (lex_op)
               OP_ASSIGN: emit_token(TK_ASSIGN, 6'd1, '0);
               OP_BANG:   emit_token(TK_ERROR, 6'd1, '0);
               OP_LT:     emit_token(TK_LT, 6'd1, '0);
               default:   emit_token(TK_GT, 6'd1, '0);
            endcase
         end
         default: ;
      endcase
      clear_lexeme();
   endfunction

   function automatic void start_lexeme(input logic [CHAR_W-1:0] c);
      if (is_blank(c)) begin
      end else if (is_letter(c) || c == CH_UNDERSCORE) begin
         lex_mode     = MODE_IDENT;
         lex_count    = 6'd1;
         lex_spelling = {24'd0, c};
      end else if (is_digit(c)) begin
         lex_mode   = MODE_NUMBER;
         lex_count  = 6'd1;
         lex_number = {24'd0, c - CH_ZERO};
      end else begin
         case (c)
            CH_EQUALS:  begin lex_mode = MODE_OP; lex_op = OP_ASSIGN; end
            CH_BANG:    begin lex_mode = MODE_OP; lex_op = OP_BANG; end
            CH_LESS:    begin lex_mode = MODE_OP; lex_op = OP_LT; end
            CH_GREATER: begin lex_mode = MODE_OP; lex_op = OP_GT; end
            CH_SEMI:    emit_token(TK_SEMI, 6'd1, '0);
            CH_LPAREN:  emit_token(TK_LPAREN, 6'd1, '0);
            CH_RPAREN:  emit_token(TK_RPAREN, 6'd1, '0);
            CH_LBRACE:  emit_token(TK_LBRACE, 6'd1, '0);
            CH_RBRACE:  emit_token(TK_RBRACE, 6'd1, '0);
            default:    emit_token(TK_ERROR, 6'd1, '0);
         endcase
      end
   endfunction

   // Works out the tokens that one byte causes; they are left in byte_tokens.
   function automatic void tokenize_byte(input logic [CHAR_W-1:0] c);
      byte_tokens.delete();
      if (c == CH_NUL) begin
         flush_lexeme();
         emit_token(TK_END, 6'd0, '0);
      end else begin
         case (lex_mode)
            MODE_IDENT: begin
               if (is_letter(c) || is_digit(c) || c == CH_UNDERSCORE) begin
                  if (lex_count < MAX_TEXT) begin
                     lex_spelling = {lex_spelling[KWBUF_W-9:0], c};
                     lex_count++;
                  end
               end else begin
                  flush_lexeme();
                  start_lexeme(c);
               end
            end
            MODE_NUMBER: begin
               if (is_digit(c)) begin
                  // The value keeps counting digits after the length has saturated.
                  lex_number = lex_number * 32'd10 + {24'd0, c - CH_ZERO};
                  if (lex_count < MAX_TEXT) lex_count++;
               end else begin
                  flush_lexeme();
                  start_lexeme(c);
               end
            end
            MODE_OP: begin
               if (c == CH_EQUALS) begin
                  case (lex_op)
                     OP_ASSIGN: emit_token(TK_EQ, 6'd2, '0);
                     OP_BANG:   emit_token(TK_NEQ, 6'd2, '0);
                     OP_LT:     emit_token(TK_LTE, 6'd2, '0);
                     default:   emit_token(TK_GTE, 6'd2, '0);
                  endcase
                  clear_lexeme();
               end else begin
                  flush_lexeme();
                  start_lexeme(c);
               end
            end
            default: start_lexeme(c);
         endcase
      end
   endfunction

   function automatic void record_request(input stim_row_type row);
      rsp_entry_type t;
      tokenize_byte(row.code);
      if (row.typed) begin
         byte_tokens.delete();
         emit_token(row.kind, row.len, '0);
      end
      for (int k = 0; k < byte_tokens.size(); k++) begin
         t      = byte_tokens[k];
         t.last = (k == byte_tokens.size() - 1);
         expected_tokens.push_back(t);
      end
   endfunction

   function automatic void add_byte(input logic [CHAR_W-1:0] c);
      stim_row_type row;
      row.code  = c;
      row.typed = 1'b0;
      row.kind  = TK_END;
      row.len   = '0;
      stimulus.push_back(row);
      random_bytes++;
   endfunction

   function automatic void add_text(input string s);
      for (int k = 0; k < s.len(); k++) add_byte(s[k]);
   endfunction

   function automatic logic [CHAR_W-1:0] word_char(input bit leading);
      int unsigned r;
      r = $urandom_range(0, leading ? 52 : 62);
      if (r < 26) return 8'(CH_LOW_A + r);
      else if (r < 52) return 8'(CH_UP_A + r - 26);
      else if (r == 52) return CH_UNDERSCORE;
      else return 8'(CH_ZERO + r - 53);
   endfunction

   // Mostly well-formed lexemes with random content, some noise and end markers.
   function automatic void add_fragment();
      int unsigned pick;
      int unsigned count;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         count = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
         for (int k = 0; k < count; k++) add_byte(word_char(k == 0));
      end else if (pick < 30) begin
         add_text(keyword_text[$urandom_range(0, 3)]);
         if ($urandom_range(0, 3) == 0) add_byte(word_char(1'b0));
      end else if (pick < 50) begin
         case ($urandom_range(0, 24))
            0:       count = $urandom_range(60, 70);
            1, 2, 3: count = $urandom_range(11, 22);
            default: count = $urandom_range(1, 10);
         endcase
         for (int k = 0; k < count; k++) add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
      end else if (pick < 68) begin
         add_text(operator_text[$urandom_range(0, 7)]);
      end else if (pick < 78) begin
         add_byte(symbol_code[$urandom_range(0, 4)]);
      end else if (pick < 88) begin
         add_byte(8'($urandom_range(1, 255)));
      end else if (pick < 92) begin
         add_byte(CH_NUL);
      end else begin
         add_byte(blank_code[$urandom_range(0, 5)]);
      end
      if ($urandom_range(0, 9) < 5) add_byte(blank_code[$urandom_range(0, 5)]);
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Request side.
   initial begin
      req_if.valid     <= 1'b0;
      req_if.char_code <= '0;
      clear_lexeme();
      foreach (directed_rows[k]) stimulus.push_back(directed_rows[k]);
      while (random_bytes < RANDOM_ITEMS) add_fragment();
      @(posedge clock);
      while (reset) @(posedge clock);

      for (int i = 0; i < stimulus.size(); i++) begin
         if (i >= stimulus.size() - CALM_TAIL) calm_tail = 1'b1;
         if (!calm_tail && !hold_active && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         req_if.valid     <= 1'b1;
         req_if.char_code <= stimulus[i].code;
         @(posedge clock);
         while (!req_if.ready) @(posedge clock);
         record_request(stimulus[i]);
         bytes_accepted++;
      end
      req_if.valid <= 1'b0;

      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Response side: random stalls, plus one long hold so that the token queue fills up.
   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!pressure_done && bytes_accepted >= HOLD_AT) begin
            pressure_done = 1'b1;
            hold_active   = 1'b1;
            rsp_if.ready <= 1'b0;
            for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clock);
            hold_active = 1'b0;
         end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_entry_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_tokens.size() == 0) begin
            $error("unexpected token: kind %0d, length %0d", rsp_if.token_kind,
                   rsp_if.token_length);
            mismatches++;
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_if.token_kind !== want.tok.kind) begin
               $error("token_kind: expected %0d, actual %0d", want.tok.kind, rsp_if.token_kind);
               mismatches++;
            end
            if (rsp_if.token_length !== want.tok.length) begin
               $error("token_length: expected %0d, actual %0d", want.tok.length,
                      rsp_if.token_length);
               mismatches++;
            end
            if (rsp_if.int_value !== want.tok.value) begin
               $error("int_value: expected %0d, actual %0d", want.tok.value, rsp_if.int_value);
               mismatches++;
            end
            if (rsp_if.last_of_run !== want.last) begin
               $error("last_of_run: expected %0d, actual %0d", want.last, rsp_if.last_of_run);
               mismatches++;
            end
         end
      end
   end

   // Ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

endmodule
